FILE: hdl/gsms_pkg.sv
// ----------------------------------------------------------------------------
// gsms_pkg
// Shared types, constants and codes of the golden-section minimum search.
// ----------------------------------------------------------------------------
package gsms_pkg;

   localparam int POINT_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int VALUE_BITS = 32;
   localparam int PREC_BITS  = 16;
   localparam int EVAL_BITS  = 24;
   localparam int FLAG_BITS  = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // golden ratio factors in unsigned Q1.32
   localparam int GOLD_FRAC = 32;
   localparam int K_BITS    = 33;
   localparam logic [K_BITS-1:0] ALPHA_Q = 33'd1640531527;
   localparam logic [K_BITS-1:0] GAMMA_Q = 33'd6949403065;

   typedef logic signed [POINT_BITS-1:0] point_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [EVAL_BITS-1:0]         eval_type;

   localparam point_type POINT_MAX = {1'b0, {(POINT_BITS-1){1'b1}}};
   localparam point_type POINT_MIN = {1'b1, {(POINT_BITS-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam eval_type  EVALS_MAX = {EVAL_BITS{1'b1}};

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_VALUE = 1'b1;

   localparam int BOUND_A = 0;
   localparam int BOUND_B = 1;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_FA      = 7'b0000010,
      PH_FB      = 7'b0000100,
      PH_INNER   = 7'b0001000,
      PH_BRACKET = 7'b0010000,
      PH_NARROW  = 7'b0100000,
      PH_STOP    = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      ST_EVAL           = 3'd0,
      ST_CONVERGED      = 3'd1,
      ST_ERROR          = 3'd2,
      ST_BUDGET_OPEN    = 3'd3,
      ST_BUDGET_BRACKET = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INTERVAL_A = 3'd0,
      CSR_INTERVAL_B = 3'd1,
      CSR_BOUND_FLAGS = 3'd2,
      CSR_PRECISION  = 3'd3,
      CSR_MAX_EVALS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      point_type              interval_a;
      point_type              interval_b;
      logic [FLAG_BITS-1:0]   bound_flags;
      logic [PREC_BITS-1:0]   precision;
      eval_type               max_evals;
   } csr_type;

   typedef struct packed {
      point_type side_point;
      value_type side_value;
      point_type mid_point;
      value_type mid_value;
      point_type far_point;
      value_type far_value;
      point_type probe_point;
      phase_type phase;
      eval_type  evals_done;
   } search_state_type;

   typedef struct packed {
      status_type status;
      point_type  request_point;
      point_type  best_point;
      value_type  best_value;
      point_type  low_point;
      value_type  low_value;
      point_type  high_point;
      value_type  high_value;
      eval_type   eval_count;
   } result_type;

endpackage

FILE: hdl/golden_section_min_search.sv
// ----------------------------------------------------------------------------
// golden_section_min_search
// Reverse-communication golden-section minimizer on Q16.16 points.
// ----------------------------------------------------------------------------
// Usage: set the interval, bound flags, precision and evaluation budget on
// the csr channel (always ready) while no beat is in flight. A req beat with
// mode 0 starts a search; the rsp beat asks for f at rsp_request_point
// (status 0). Each following req beat with mode 1 carries that value and its
// point; the answer is the next point, or a final status (converged, error,
// budget out) with the bracket and best point.
// An accepted req beat is registered in the input register, then stepped
// through one compare/update and one golden multiply into the rsp register,
// which raises rsp_valid. Throughput is one beat per cycle while rsp_stall
// is low; the single step path between the two registers sets it.
// rsp_stall holds the result register; the input register then fills and
// req_stall rises until the result is taken. Reset (synchronous) empties both
// registers, loads the csr reset values and returns the search to idle with
// all stored points and values at zero.
// ----------------------------------------------------------------------------
module golden_section_min_search import gsms_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  point_type                 req_point_echo,
   input  value_type                 req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output status_type                rsp_status,
   output point_type                 rsp_request_point,
   output point_type                 rsp_best_point,
   output value_type                 rsp_best_value,
   output point_type                 rsp_low_point,
   output value_type                 rsp_low_value,
   output point_type                 rsp_high_point,
   output value_type                 rsp_high_value,
   output eval_type                  rsp_eval_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   csr_type          csr_ff, csr_in;
   search_state_type state_ff, state_in;
   logic             in_valid_ff, in_valid_in;
   logic             in_mode_ff;
   point_type        in_echo_ff;
   value_type        in_value_ff;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff;
   search_state_type step_state;
   result_type       step_result;
   logic             advance;
   logic             req_accept;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL_A:  csr_in.interval_a  = point_type'(csr_data);
            CSR_INTERVAL_B:  csr_in.interval_b  = point_type'(csr_data);
            CSR_BOUND_FLAGS: csr_in.bound_flags = csr_data[FLAG_BITS-1:0];
            CSR_PRECISION:   csr_in.precision   = csr_data[PREC_BITS-1:0];
            CSR_MAX_EVALS:   csr_in.max_evals   = csr_data[EVAL_BITS-1:0];
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      state_in = advance ? step_state : state_ff;
   end

   gsms_step u_step (
      .csr        (csr_ff),
      .cur        (state_ff),
      .mode       (in_mode_ff),
      .point_echo (in_echo_ff),
      .value      (in_value_ff),
      .nxt        (step_state),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.interval_a  <= '0;
         csr_ff.interval_b  <= point_type'(1) <<< FRAC_BITS;
         csr_ff.bound_flags <= '0;
         csr_ff.precision   <= PREC_BITS'(1);
         csr_ff.max_evals   <= '0;
         state_ff.side_point  <= '0;
         state_ff.side_value  <= '0;
         state_ff.mid_point   <= '0;
         state_ff.mid_value   <= '0;
         state_ff.far_point   <= '0;
         state_ff.far_value   <= '0;
         state_ff.probe_point <= '0;
         state_ff.phase       <= PH_IDLE;
         state_ff.evals_done  <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff  <= req_mode;
         in_echo_ff  <= req_point_echo;
         in_value_ff <= req_value;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_request_point = out_ff.request_point;
   assign rsp_best_point    = out_ff.best_point;
   assign rsp_best_value    = out_ff.best_value;
   assign rsp_low_point     = out_ff.low_point;
   assign rsp_low_value     = out_ff.low_value;
   assign rsp_high_point    = out_ff.high_point;
   assign rsp_high_value    = out_ff.high_value;
   assign rsp_eval_count    = out_ff.eval_count;

   // search state moves only with a beat going to the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("search state changed without a beat");

   // any final status leaves the search stopped
   a_final_stops: assert property (@(posedge clock) disable iff (reset)
      (advance && (step_result.status != ST_EVAL)) |=> (state_ff.phase == PH_STOP))
      else $error("final status without stopped search");

   // a point request leaves the search waiting for that value
   a_request_waits: assert property (@(posedge clock) disable iff (reset)
      (advance && (step_result.status == ST_EVAL)) |=>
         ((state_ff.phase == PH_FA) || (state_ff.phase == PH_FB) ||
          (state_ff.phase == PH_INNER) || (state_ff.phase == PH_BRACKET) ||
          (state_ff.phase == PH_NARROW)) &&
         (rsp_request_point == state_ff.probe_point))
      else $error("point request without a waiting search");

endmodule

FILE: hdl/gsms_golden.sv
// ----------------------------------------------------------------------------
// gsms_golden
// Golden step: base + round(k * (to - from) / 2^32), saturated to a point.
// ----------------------------------------------------------------------------
module gsms_golden import gsms_pkg::*; (
   input  point_type base,
   input  point_type from_point,
   input  point_type to_point,
   input  logic      use_gamma,
   output point_type point
);

   localparam int DW   = POINT_BITS + 1;
   localparam int PW   = DW + K_BITS;
   localparam int SBW  = PW - GOLD_FRAC;
   localparam int SUMW = SBW + 2;

   logic signed [DW-1:0]   diff;
   logic                   neg;
   logic [DW-1:0]          mag;
   logic [K_BITS-1:0]      k;
   logic [PW-1:0]          prod;
   logic [PW-1:0]          prod_rnd;
   logic [SBW-1:0]         step;
   logic signed [SUMW-1:0] base_x;
   logic signed [SUMW-1:0] step_x;
   logic signed [SUMW-1:0] sum;
   logic [SUMW-POINT_BITS:0] top_bits;
   logic                   fits;

   always_comb begin
      diff = $signed({to_point[POINT_BITS-1], to_point})
           - $signed({from_point[POINT_BITS-1], from_point});
      neg  = diff[DW-1];
      mag  = neg ? (~diff + 1'b1) : diff;
      k    = use_gamma ? GAMMA_Q : ALPHA_Q;
      prod = PW'(mag) * PW'(k);
      // round half away from zero on the magnitude
      prod_rnd = prod + PW'({1'b1, {(GOLD_FRAC-1){1'b0}}});
      step     = prod_rnd[PW-1:GOLD_FRAC];
      base_x   = $signed({{(SUMW-POINT_BITS){base[POINT_BITS-1]}}, base});
      step_x   = $signed({2'b00, step});
      sum      = neg ? (base_x - step_x) : (base_x + step_x);
      top_bits = sum[SUMW-1:POINT_BITS-1];
      fits     = (&top_bits) || (~|top_bits);
      if (fits) begin
         point = sum[POINT_BITS-1:0];
      end else if (sum[SUMW-1]) begin
         point = POINT_MIN;
      end else begin
         point = POINT_MAX;
      end
   end

endmodule

FILE: hdl/gsms_conv.sv
// ----------------------------------------------------------------------------
// gsms_conv
// Convergence test: |w-v| * 2^16 <= precision * max(|u|,|v|,|w|), exact.
// ----------------------------------------------------------------------------
module gsms_conv import gsms_pkg::*; (
   input  point_type            side_point,
   input  point_type            mid_point,
   input  point_type            far_point,
   input  logic [PREC_BITS-1:0] precision,
   output logic                 converged
);

   localparam int DW = POINT_BITS + 1;

   function automatic logic [POINT_BITS-1:0] magnitude(input point_type x);
      logic [POINT_BITS-1:0] m;
      m = x[POINT_BITS-1] ? (~x + 1'b1) : x;
      return m;
   endfunction

   logic [POINT_BITS-1:0]           mag_u;
   logic [POINT_BITS-1:0]           mag_v;
   logic [POINT_BITS-1:0]           mag_w;
   logic [POINT_BITS-1:0]           span;
   logic signed [DW-1:0]            diff;
   logic [DW-1:0]                   gap_mag;
   logic [DW+PREC_BITS-1:0]         lhs;
   logic [POINT_BITS+PREC_BITS-1:0] rhs;

   always_comb begin
      mag_u = magnitude(side_point);
      mag_v = magnitude(mid_point);
      mag_w = magnitude(far_point);
      span  = mag_u;
      if (mag_v > span) begin
         span = mag_v;
      end
      if (mag_w > span) begin
         span = mag_w;
      end
      diff = $signed({far_point[POINT_BITS-1], far_point})
           - $signed({mid_point[POINT_BITS-1], mid_point});
      gap_mag = diff[DW-1] ? (~diff + 1'b1) : diff;
      lhs  = {gap_mag, {PREC_BITS{1'b0}}};
      rhs  = (POINT_BITS+PREC_BITS)'(span) * (POINT_BITS+PREC_BITS)'(precision);
      converged = lhs <= {1'b0, rhs};
   end

endmodule

FILE: hdl/gsms_step.sv
// ----------------------------------------------------------------------------
// gsms_step
// One search step: applies a beat to the search state and forms the result.
// ----------------------------------------------------------------------------
module gsms_step import gsms_pkg::*; (
   input  csr_type          csr,
   input  search_state_type cur,
   input  logic             mode,
   input  point_type        point_echo,
   input  value_type        value,
   output search_state_type nxt,
   output result_type       result
);

   typedef enum logic [2:0] {
      RT_ERROR    = 3'd0,
      RT_ASK_FA   = 3'd1,
      RT_ASK_FB   = 3'd2,
      RT_INTERIOR = 3'd3,
      RT_BRACKET  = 3'd4,
      RT_NARROW   = 3'd5
   } routine_type;

   search_state_type t;
   search_state_type t2;
   routine_type      rt;
   logic             waiting;
   logic             climb;
   logic             budget_out;
   logic             converged;
   point_type        g_base;
   point_type        g_from;
   point_type        g_to;
   logic             g_gamma;
   point_type        g_point;
   status_type       status;
   logic             lo_is_far;

   // apply the beat to the stored points and pick the follow-up action
   always_comb begin
      t  = cur;
      rt = RT_ERROR;
      waiting = (cur.phase == PH_FA) || (cur.phase == PH_FB) ||
                (cur.phase == PH_INNER) || (cur.phase == PH_BRACKET) ||
                (cur.phase == PH_NARROW);
      if (mode == MODE_START) begin
         if (csr.interval_a != csr.interval_b) begin
            t.evals_done = '0;
            t.side_point = csr.interval_a;
            t.far_point  = csr.interval_b;
            if (!csr.bound_flags[BOUND_A]) begin
               rt = RT_ASK_FA;
            end else begin
               t.side_value = VALUE_MAX;
               if (!csr.bound_flags[BOUND_B]) begin
                  rt = RT_ASK_FB;
               end else begin
                  t.far_value = VALUE_MAX;
                  rt = RT_INTERIOR;
               end
            end
         end
      end else if (waiting && (point_echo == cur.probe_point)) begin
         if (cur.evals_done != EVALS_MAX) begin
            t.evals_done = cur.evals_done + 1'b1;
         end
         unique case (cur.phase)
            PH_FA: begin
               t.side_value = value;
               if (!csr.bound_flags[BOUND_B]) begin
                  rt = RT_ASK_FB;
               end else begin
                  t.far_value = VALUE_MAX;
                  rt = RT_INTERIOR;
               end
            end
            PH_FB: begin
               t.far_value = value;
               rt = RT_INTERIOR;
            end
            PH_INNER: begin
               t.mid_point = cur.probe_point;
               t.mid_value = value;
               rt = RT_BRACKET;
            end
            PH_BRACKET: begin
               t.far_point = cur.probe_point;
               t.far_value = value;
               rt = RT_BRACKET;
            end
            PH_NARROW: begin
               if ((value > cur.mid_value) ||
                   ((value == cur.mid_value) && (cur.side_value >= cur.far_value))) begin
                  t.far_point  = cur.side_point;
                  t.far_value  = cur.side_value;
                  t.side_point = cur.probe_point;
                  t.side_value = value;
               end else begin
                  t.side_point = cur.mid_point;
                  t.side_value = cur.mid_value;
                  t.mid_point  = cur.probe_point;
                  t.mid_value  = value;
               end
               rt = RT_NARROW;
            end
            default: begin
               rt = RT_ERROR;
            end
         endcase
      end
   end

   // interior end swap, climb and budget tests, operands of the shared golden step
   always_comb begin
      t2 = t;
      if ((rt == RT_INTERIOR) && (t.far_value > t.side_value)) begin
         t2.side_point = t.far_point;
         t2.side_value = t.far_value;
         t2.far_point  = t.side_point;
         t2.far_value  = t.side_value;
      end
      climb      = t.mid_value > t.far_value;
      budget_out = (csr.max_evals != '0) && (t.evals_done >= csr.max_evals);
      if (rt == RT_INTERIOR) begin
         g_base  = t2.side_point;
         g_from  = t2.side_point;
         g_to    = t2.far_point;
         g_gamma = 1'b0;
      end else if ((rt == RT_BRACKET) && climb) begin
         // outward step past the far end
         g_base  = t.far_point;
         g_from  = t.mid_point;
         g_to    = t.far_point;
         g_gamma = 1'b1;
      end else begin
         g_base  = t.mid_point;
         g_from  = t.mid_point;
         g_to    = t.far_point;
         g_gamma = 1'b0;
      end
   end

   gsms_golden u_golden (
      .base       (g_base),
      .from_point (g_from),
      .to_point   (g_to),
      .use_gamma  (g_gamma),
      .point      (g_point)
   );

   gsms_conv u_conv (
      .side_point (t.side_point),
      .mid_point  (t.mid_point),
      .far_point  (t.far_point),
      .precision  (csr.precision),
      .converged  (converged)
   );

   always_comb begin
      nxt    = t2;
      status = ST_EVAL;
      unique case (rt)
         RT_ERROR: begin
            nxt.phase = PH_STOP;
            status    = ST_ERROR;
         end
         RT_ASK_FA: begin
            nxt.probe_point = t.side_point;
            nxt.phase       = PH_FA;
         end
         RT_ASK_FB: begin
            nxt.probe_point = t.far_point;
            nxt.phase       = PH_FB;
         end
         RT_INTERIOR: begin
            nxt.probe_point = g_point;
            nxt.phase       = PH_INNER;
         end
         default: begin
            if ((rt == RT_BRACKET) && climb) begin
               if (budget_out) begin
                  nxt.phase = PH_STOP;
                  status    = ST_BUDGET_OPEN;
               end else begin
                  nxt.side_point  = t.mid_point;
                  nxt.side_value  = t.mid_value;
                  nxt.mid_point   = t.far_point;
                  nxt.mid_value   = t.far_value;
                  nxt.probe_point = g_point;
                  nxt.phase       = PH_BRACKET;
               end
            end else if (converged) begin
               nxt.phase = PH_STOP;
               status    = ST_CONVERGED;
            end else if (budget_out) begin
               nxt.phase = PH_STOP;
               status    = ST_BUDGET_BRACKET;
            end else begin
               nxt.probe_point = g_point;
               nxt.phase       = PH_NARROW;
            end
         end
      endcase
   end

   always_comb begin
      lo_is_far            = nxt.side_point > nxt.far_point;
      result.status        = status;
      result.request_point = (status == ST_EVAL) ? nxt.probe_point : '0;
      result.best_point    = nxt.mid_point;
      result.best_value    = nxt.mid_value;
      result.low_point     = lo_is_far ? nxt.far_point  : nxt.side_point;
      result.low_value     = lo_is_far ? nxt.far_value  : nxt.side_value;
      result.high_point    = lo_is_far ? nxt.side_point : nxt.far_point;
      result.high_value    = lo_is_far ? nxt.side_value : nxt.far_value;
      result.eval_count    = nxt.evals_done;
   end

endmodule
